// ===== rtl/wqte_pkg.sv =====
// ----------------------------------------------------------------------------
// wqte_pkg: shared definitions for the windowed quality trend estimator
// Field widths, the trend band, trend codes and the sequencer state type.
// ----------------------------------------------------------------------------
package wqte_pkg;

  // Quality values are unsigned fixed point with 65536 standing for 1.0.
  localparam int unsigned QW            = 17;
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned ITERS_W       = 32;
  localparam int unsigned FILLED_W      = 7;
  localparam int unsigned S_TDATA_W     = 24;
  localparam int unsigned M_TDATA_W     = 64;

  // Band of 0.05 around zero difference that still counts as stable.
  localparam logic signed [QW:0] TREND_BAND = 18'sd3277;

  localparam logic [QW-1:0] TARGET_RESET = 17'd65536;

  typedef enum logic [1:0] {
    TREND_UP   = 2'd0,
    TREND_FLAT = 2'd1,
    TREND_DOWN = 2'd2,
    TREND_NONE = 2'd3
  } trend_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/windowed_quality_trend_estimator.sv =====
// ----------------------------------------------------------------------------
// windowed_quality_trend_estimator
// Keeps the last DEPTH quality samples in a ring memory and reports trend,
// per-sample rate and the estimated number of samples left to the target.
// ----------------------------------------------------------------------------
//  channel   direction  contents (lowest bit first)
//  cfg       in         cfg_wdata: target_level[16:0]
//  s_*       in         s_tdata: quality_sample[16:0], zero pad to 24 bits
//  m_*       out        m_tdata: trend[1:0], rate[18:2], iterations_left[50:19],
//                                filled[57:51], zero pad to 64 bits
//
//  One sample is handled at a time: after a transfer the block reads the
//  oldest entry, then the two serial dividers run side by side for
//  PW = 17 + clog2(DEPTH + 1) steps, and the result is registered in the
//  done state before the next transfer is accepted. A new
//  sample is taken while that result still waits on m_tready.
//  Reset is synchronous; no clearing pass is needed, as only written ring
//  entries are read.
// ----------------------------------------------------------------------------
module windowed_quality_trend_estimator
  import wqte_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [QW-1:0]        cfg_wdata,   // target level
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,     // quality_sample, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata      // trend, rate, iterations_left, filled, pad
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = $clog2(DEPTH + 1);
  localparam int unsigned PW    = QW + FW;
  localparam int unsigned CW    = $clog2(PW + 1);

  state_t state, state_next;

  logic [QW-1:0]    target_level;
  logic [PTR_W-1:0] write_pointer;
  logic [FW-1:0]    fill_count;

  logic [QW-1:0]    ring [DEPTH];
  logic [QW-1:0]    rd_data;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rd_addr;
  logic             accept;
  logic [FW-1:0]    fill_inc;

  // Per-item working registers
  logic [QW-1:0]        sample_q;
  logic [FW-1:0]        fill_q;
  logic signed [QW:0]   diff_q;
  logic                 at_target_q;
  logic [CW-1:0]        step_cnt;

  // Estimate divider: gap * fill / diff
  logic [PW-1:0] iquo;
  logic [QW-1:0] irem;
  logic [QW-1:0] idiv;
  // Rate divider: |diff| / fill
  logic [PW-1:0] rquo;
  logic [FW-1:0] rrem;

  logic signed [QW:0] diff_c;
  logic [QW-1:0]      mag_c;
  logic [QW-1:0]      gap_c;
  logic [PW-1:0]      prod_c;

  logic [QW:0]   itrial;
  logic          ibit;
  logic [QW-1:0] irem_next;
  logic [FW:0]   rtrial;
  logic          rbit;
  logic [FW-1:0] rrem_next;

  logic               out_load;
  trend_t             trend_c;
  logic [QW-1:0]      rate_c;
  logic [ITERS_W-1:0] iters_c;
  logic [QW-1:0]      rate_mag;

  trend_t             trend_r;
  logic [QW-1:0]      rate_r;
  logic [ITERS_W-1:0] iters_r;
  logic [FILLED_W-1:0] filled_r;

  assign accept   = s_tvalid && s_tready;
  assign wp_inc   = (write_pointer == PTR_W'(DEPTH - 1)) ? '0 : write_pointer + 1'b1;
  assign fill_inc = (fill_count == FW'(DEPTH)) ? fill_count : fill_count + 1'b1;
  // Until the ring wraps the oldest sample sits in entry zero; once full it
  // is the entry right after the one being overwritten.
  assign rd_addr  = (fill_count == FW'(DEPTH)) ? wp_inc : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_pointer] <= s_tdata[QW-1:0];
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_RESET;
    end else if (cfg_we) begin
      target_level <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      fill_count    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        write_pointer <= wp_inc;
        fill_count    <= fill_inc;
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (step_cnt == CW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Set-up arithmetic, evaluated while the oldest sample arrives
  always_comb begin
    diff_c = $signed({1'b0, sample_q}) - $signed({1'b0, rd_data});
    mag_c  = diff_c[QW] ? QW'(-diff_c) : diff_c[QW-1:0];
    gap_c  = target_level - sample_q;
    prod_c = PW'(gap_c) * PW'(fill_q);
  end

  // One restoring step for each divider
  always_comb begin
    itrial    = {irem, iquo[PW-1]};
    ibit      = (itrial >= {1'b0, idiv});
    irem_next = ibit ? QW'(itrial - {1'b0, idiv}) : itrial[QW-1:0];
    rtrial    = {rrem, rquo[PW-1]};
    rbit      = (rtrial >= {1'b0, fill_q});
    rrem_next = rbit ? FW'(rtrial - {1'b0, fill_q}) : rtrial[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= s_tdata[QW-1:0];
      fill_q   <= fill_inc;
    end
    unique case (state)
      S_READ: begin
        diff_q      <= diff_c;
        at_target_q <= (sample_q >= target_level);
        iquo        <= prod_c;
        irem        <= '0;
        idiv        <= diff_c[QW-1:0];
        rquo        <= PW'(mag_c);
        rrem        <= '0;
        step_cnt    <= CW'(PW);
      end
      S_DIV: begin
        iquo     <= {iquo[PW-2:0], ibit};
        irem     <= irem_next;
        rquo     <= {rquo[PW-2:0], rbit};
        rrem     <= rrem_next;
        step_cnt <= step_cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rate_mag = rquo[QW-1:0];
    if (fill_q < FW'(2)) begin
      trend_c = TREND_NONE;
      rate_c  = '0;
      iters_c = '0;
    end else begin
      priority if (diff_q > TREND_BAND) begin
        trend_c = TREND_UP;
      end else if (diff_q < -TREND_BAND) begin
        trend_c = TREND_DOWN;
      end else begin
        trend_c = TREND_FLAT;
      end
      rate_c = diff_q[QW] ? QW'(-rate_mag) : rate_mag;
      priority if (diff_q[QW] || (diff_q == '0)) begin
        iters_c = '1;
      end else if (at_target_q) begin
        iters_c = '0;
      end else begin
        iters_c = ITERS_W'(iquo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      trend_r  <= trend_c;
      rate_r   <= rate_c;
      iters_r  <= iters_c;
      filled_r <= FILLED_W'(fill_q);
    end
  end

  assign m_tdata = {{(M_TDATA_W - 2 - QW - ITERS_W - FILLED_W){1'b0}},
                    filled_r, iters_r, rate_r, trend_r};

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(DEPTH))
    else $error("fill count above ring depth");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count < FW'(DEPTH)) |-> (FW'(write_pointer) == fill_count))
    else $error("write pointer out of step with fill count before wrap");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted sample did not start a read");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((step_cnt != '0) && (step_cnt <= CW'(PW))))
    else $error("divider step count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while held");
`endif

endmodule

// ===== bench/tb_windowed_quality_trend_estimator.sv =====
// ----------------------------------------------------------------------------
// Testbench for windowed_quality_trend_estimator
// Streams quality samples through the block with bursty input and a stalling
// output side, predicts every result from a ring model kept in a scoreboard,
// and compares trend, rate, estimate and fill count field by field. The
// target register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_windowed_quality_trend_estimator
  import wqte_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING      = DEPTH_DEFAULT;
  localparam int QMAX      = (1 << QW) - 1;
  localparam int SETTLE    = 40;
  localparam int PHASE_LEN = 200;

  typedef struct {
    trend_t               trend;
    logic [QW-1:0]        rate;
    logic [ITERS_W-1:0]   iters;
    logic [FILLED_W-1:0]  filled;
  } trend_result_t;

  typedef enum int {SEG_RAMP, SEG_FLAT, SEG_EDGE, SEG_NOISE} seg_kind_t;

  class trend_scoreboard;
    logic [QW-1:0]  ring [RING];
    int             wr_ptr;
    int             fill;
    logic [QW-1:0]  target;
    trend_result_t  expected_q [$];
    int             errors;

    function new();
      wr_ptr = 0;
      fill   = 0;
      target = TARGET_RESET;
      errors = 0;
    endfunction

    function void set_target(logic [QW-1:0] value);
      target = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Stores the sample and works out the result for the window after it.
    function void note_sample(logic [QW-1:0] sample);
      trend_result_t r;
      int            newest, oldest, diff, per_sample;
      longint        gap, estimate;
      ring[wr_ptr] = sample;
      wr_ptr = (wr_ptr + 1) % RING;
      if (fill < RING) fill++;
      r.filled = fill[FILLED_W-1:0];
      if (fill < 2) begin
        r.trend = TREND_NONE;
        r.rate  = '0;
        r.iters = '0;
      end else begin
        newest = ring[(wr_ptr + RING - 1) % RING];
        oldest = ring[(wr_ptr + RING - fill) % RING];
        diff   = newest - oldest;
        if (diff > int'(TREND_BAND)) r.trend = TREND_UP;
        else if (diff < -int'(TREND_BAND)) r.trend = TREND_DOWN;
        else r.trend = TREND_FLAT;
        // Signed integer division truncates toward zero.
        per_sample = diff / fill;
        r.rate = per_sample[QW-1:0];
        if (diff <= 0) begin
          r.iters = '1;
        end else if (newest >= int'(target)) begin
          r.iters = '0;
        end else begin
          gap      = longint'(target) - newest;
          estimate = (gap * fill) / diff;
          if (estimate > longint'(32'hFFFF_FFFF)) estimate = 32'hFFFF_FFFF;
          r.iters = estimate[ITERS_W-1:0];
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [M_TDATA_W-1:0] data);
      trend_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", data, '0);
      end else begin
        want = expected_q.pop_front();
        if (data[1:0] != want.trend) report("trend", data[1:0], want.trend);
        if (data[18:2] != want.rate) report("rate", data[18:2], want.rate);
        if (data[50:19] != want.iters) report("iterations_left", data[50:19], want.iters);
        if (data[57:51] != want.filled) report("filled", data[57:51], want.filled);
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [QW-1:0]        cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  trend_scoreboard sb = new();
  int burst_left = 0;

  // Oldest entry stays at 40000 here, so the band edges and target cases
  // can be hit exactly.
  int opening_seq [16] = '{40000, 40000, 43277, 43278, 36723, 36722, 65535, 65536,
                           131071, 40001, 0, 100000, 65537, 20000, 43277, 131071};

  windowed_quality_trend_estimator #(.DEPTH(RING)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output side: each stretch picks a stall pattern, from always ready to
  // long periodic stalls.
  int rx_left = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_left % 64) >= 48);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic logic [QW-1:0] clamp_q(int v);
    if (v < 0) return '0;
    if (v > QMAX) return QW'(QMAX);
    return v[QW-1:0];
  endfunction

  task automatic send_sample(input logic [QW-1:0] sample);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - QW){1'b0}}, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(sample);
    burst_left--;
  endtask

  task automatic stop_sending();
    s_tvalid   <= 1'b0;
    burst_left = 0;
  endtask

  task automatic write_target(input logic [QW-1:0] value);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_target(value);
  endtask

  // Mostly ramps and plateaus of random slope, with edge values and noise.
  task automatic run_phase(input int n_items);
    int        sent, r, len, start, step, span, v;
    seg_kind_t kind;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      kind = (r < 6) ? SEG_RAMP : (r == 6) ? SEG_FLAT : (r == 7) ? SEG_EDGE : SEG_NOISE;
      start = $urandom_range(0, QMAX);
      case ($urandom_range(0, 2))
        0: span = 40;
        1: span = 600;
        default: span = 4000;
      endcase
      step = $urandom_range(0, 2 * span) - span;
      len  = (kind == SEG_NOISE) ? $urandom_range(1, 10) : $urandom_range(4, 40);
      for (int k = 0; k < len && sent < n_items; k++) begin
        case (kind)
          SEG_RAMP: v = start + k * step + $urandom_range(0, 40) - 20;
          SEG_FLAT: v = start + $urandom_range(0, 100) - 50;
          SEG_EDGE: begin
            case ($urandom_range(0, 5))
              0: v = 0;
              1: v = QMAX;
              2: v = int'(sb.target) - 1;
              3: v = int'(sb.target);
              4: v = int'(sb.target) + 1;
              default: v = 65536;
            endcase
          end
          default: v = $urandom_range(0, QMAX);
        endcase
        send_sample(clamp_q(v));
        sent++;
      end
    end
    stop_sending();
  endtask

  initial begin
    logic [QW-1:0] targets [8];
    targets = '{17'd0, 17'd131071, 17'd65536, 17'd65535, 17'd1, 17'd0, 17'd0, 17'd65536};
    targets[5] = QW'($urandom_range(1, 65535));
    targets[6] = QW'($urandom_range(65537, QMAX - 1));
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (opening_seq[i]) send_sample(opening_seq[i][QW-1:0]);
    stop_sending();
    foreach (targets[p]) begin
      write_target(targets[p]);
      run_phase(PHASE_LEN);
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS windowed_quality_trend_estimator");
    end else begin
      $display("FAIL windowed_quality_trend_estimator");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL windowed_quality_trend_estimator");
    $finish;
  end

endmodule
